// ----- src/ipdd_pkg.sv -----
// ============================================================================
// ipdd_pkg: shared types and constants of the image packet deframer
// Holds the input and output structs of both channels, result kinds and fixed
// constants of the packet format and the pixel decode.
// ============================================================================
`default_nettype none

package ipdd_pkg;

    localparam int PAYLOAD_WORDS_DEF = 16;

    localparam logic [31:0] MAGIC_WORD = 32'hBA2FA166;

    localparam int INDEX_W = 20;
    localparam int CSUM_W  = 12;
    localparam int PIX_W   = 24;

    localparam int          CSUM_MUL = 41;
    localparam int          DEC_MUL  = 31;
    localparam logic [7:0]  DEC_XOR  = 8'b10101010;
    localparam logic [7:0]  PREV_GAP = 8'hFF;

    typedef enum logic [2:0] {
        KIND_PIXELS   = 3'd0,
        KIND_CSUM_ERR = 3'd1,
        KIND_SIZE_ERR = 3'd2,
        KIND_RANGE    = 3'd3,
        KIND_DONE     = 3'd4,
        KIND_IGNORED  = 3'd5
    } kind_t;

    typedef enum logic {
        MODE_START = 1'b0,
        MODE_WORD  = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [31:0]        data_word;
        logic               word_last;
        logic [PIX_W-1:0]   pixel_count;
        logic               start_ok;
    } in_t;

    typedef struct packed {
        kind_t              kind;
        logic [31:0]        pixels;
        logic [PIX_W-1:0]   byte_offset;
        logic [2:0]         byte_count;
        logic               frame_valid;
        logic               last;
    } out_t;

endpackage

`default_nettype wire

// ----- src/ipdd_ram.sv -----
// ============================================================================
// ipdd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
`default_nettype none

module ipdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/ipdd_word_unit.sv -----
// ============================================================================
// ipdd_word_unit: shared per-word arithmetic unit
// Folds the four bytes of a word into the running checksum and decodes the
// first byte_cnt bytes of the same word into pixels.
// ============================================================================
`default_nettype none

module ipdd_word_unit (
    input  wire logic [ipdd_pkg::CSUM_W-1:0] csum_in,
    input  wire logic [31:0]                 word_in,
    input  wire logic [7:0]                  prev_in,
    input  wire logic [2:0]                  byte_cnt,
    output logic      [ipdd_pkg::CSUM_W-1:0] csum_out,
    output logic      [31:0]                 pix_out,
    output logic      [7:0]                  prev_out
);

    // checksum: c = c*41 + b, mod 4096, low byte first
    always_comb begin
        logic [ipdd_pkg::CSUM_W-1:0] c;
        c = csum_in;
        for (int k = 0; k < 4; k++) begin
            c = ipdd_pkg::CSUM_W'(c * ipdd_pkg::CSUM_MUL + int'(word_in[8*k +: 8]));
        end
        csum_out = c;
    end

    // decode: (raw - 31*prev_raw) ^ 0xAA; bytes past byte_cnt stay zero
    always_comb begin
        logic [7:0] raw;
        logic [7:0] pv;
        logic [7:0] dec;
        pix_out  = '0;
        prev_out = prev_in;
        for (int k = 0; k < 4; k++) begin
            raw = word_in[8*k +: 8];
            pv  = (k == 0) ? prev_in : word_in[8*(k-1) +: 8];
            dec = 8'(raw - 8'(pv * 8'(ipdd_pkg::DEC_MUL))) ^ ipdd_pkg::DEC_XOR;
            if (3'(k) < byte_cnt) begin
                pix_out[8*k +: 8] = dec;
                prev_out          = raw;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/image_packet_deframer_decoder.sv -----
// Flow: a frame start or a non-final word is handled in S_IDLE; a final word with the right
// length runs the checksum fold (S_CRD, S_CFOLD per payload word), the sequence and range
// checks (S_SEQ, S_RANGE), then S_PRD, S_PEMIT per pixel result (or S_OOR) and S_DONE.
// Throughput: one packet in flight; input waits until the block is idle and the result
// register is free, so output stalls add directly. Reset: synchronous active-low aresetn
// clears control state; the payload RAM is not cleared.
// ============================================================================
// image_packet_deframer_decoder: camera packet deframer and pixel decoder
// Checks magic, length, checksum, range and sequence of each packet, buffers
// the payload and emits decoded pixels up to four bytes per result.
// ============================================================================
`default_nettype none

module image_packet_deframer_decoder #(
    parameter int PAYLOAD_WORDS = ipdd_pkg::PAYLOAD_WORDS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire ipdd_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output ipdd_pkg::out_t      m_data
);

    localparam int PB     = 4 * PAYLOAD_WORDS;
    localparam int ADDR_W = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
    localparam int WC_W   = $clog2(PAYLOAD_WORDS + 3);
    localparam int REM_W  = $clog2(PB + 1);
    localparam int BASE_W = ipdd_pkg::INDEX_W + REM_W;
    localparam int PIX_W  = ipdd_pkg::PIX_W;
    localparam int IDX_W  = ipdd_pkg::INDEX_W;
    localparam int CS_W   = ipdd_pkg::CSUM_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CRD,
        S_CFOLD,
        S_SEQ,
        S_RANGE,
        S_OOR,
        S_PRD,
        S_PEMIT,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic                active_reg, active_next;
    logic                good_reg, good_next;
    logic                last_vld_reg, last_vld_next;
    logic [IDX_W-1:0]    last_idx_reg, last_idx_next;
    logic [WC_W-1:0]     word_cnt_reg, word_cnt_next;
    logic                magic_ok_reg, magic_ok_next;
    logic [7:0]          prev_raw_reg, prev_raw_next;
    logic [PIX_W-1:0]    frame_pix_reg, frame_pix_next;
    logic                out_valid_reg, out_valid_next;
    ipdd_pkg::out_t      out_reg, out_next;

    logic [31:0]         tail_reg, tail_next;
    logic [CS_W-1:0]     csum_reg, csum_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [PIX_W-1:0]    offset_reg, offset_next;
    logic                done_reg, done_next;

    // follows flag captured in S_SEQ, before last_idx is overwritten
    logic                follows_hold_reg;

    logic                out_free;
    logic                s_take;
    logic                ram_wr_en;
    logic                ram_rd_en;
    logic [31:0]         ram_rd_data;
    logic [2:0]          pix_cnt;
    logic [CS_W-1:0]     unit_csum;
    logic [31:0]         unit_pix;
    logic [7:0]          unit_prev;

    logic [IDX_W-1:0]    tail_idx;
    logic [CS_W-1:0]     tail_csum;
    logic                idx_zero;
    logic                follows;
    logic                in_range;
    logic [PIX_W-1:0]    diff;
    logic                magic_now;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign s_take   = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    assign tail_idx  = tail_reg[IDX_W-1:0];
    assign tail_csum = tail_reg[31 -: CS_W];
    assign idx_zero  = (tail_idx == '0);
    assign follows   = last_vld_reg &&
                       ({1'b0, tail_idx} == ({1'b0, last_idx_reg} + (IDX_W+1)'(1)));
    assign in_range  = !idx_zero &&
                       ({{PIX_W{1'b0}}, base_reg} < {{BASE_W{1'b0}}, frame_pix_reg});
    assign diff      = frame_pix_reg - PIX_W'(base_reg);
    assign magic_now = (s_data.data_word == ipdd_pkg::MAGIC_WORD);
    assign pix_cnt   = (rem_reg >= REM_W'(4)) ? 3'd4 : 3'(rem_reg);

    assign ram_wr_en = s_take && (s_data.mode == ipdd_pkg::MODE_WORD) && !s_data.word_last &&
                       (word_cnt_reg != '0) && (word_cnt_reg <= WC_W'(PAYLOAD_WORDS));
    assign ram_rd_en = (state_reg == S_CRD) || (state_reg == S_PRD);

    ipdd_ram #(
        .WIDTH (32),
        .DEPTH (PAYLOAD_WORDS)
    ) u_payload_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ADDR_W'(word_cnt_reg - WC_W'(1))),
        .wr_data (s_data.data_word),
        .rd_en   (ram_rd_en),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    ipdd_word_unit u_word_unit (
        .csum_in  (csum_reg),
        .word_in  (ram_rd_data),
        .prev_in  (prev_raw_reg),
        .byte_cnt (pix_cnt),
        .csum_out (unit_csum),
        .pix_out  (unit_pix),
        .prev_out (unit_prev)
    );

    always_comb begin
        state_next     = state_reg;
        active_next    = active_reg;
        good_next      = good_reg;
        last_vld_next  = last_vld_reg;
        last_idx_next  = last_idx_reg;
        word_cnt_next  = word_cnt_reg;
        magic_ok_next  = magic_ok_reg;
        prev_raw_next  = prev_raw_reg;
        frame_pix_next = frame_pix_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        tail_next      = tail_reg;
        csum_next      = csum_reg;
        addr_next      = addr_reg;
        base_next      = base_reg;
        rem_next       = rem_reg;
        offset_next    = offset_reg;
        done_next      = done_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_take) begin
                    if (s_data.mode == ipdd_pkg::MODE_START) begin
                        // drop any packet in progress
                        active_next   = s_data.start_ok;
                        good_next     = s_data.start_ok;
                        last_vld_next = 1'b0;
                        word_cnt_next = '0;
                        if (s_data.start_ok) begin
                            frame_pix_next = s_data.pixel_count;
                            prev_raw_next  = 8'd0;
                        end
                    end else begin
                        if (word_cnt_reg == '0) begin
                            magic_ok_next = magic_now;
                        end
                        if (!s_data.word_last) begin
                            if (word_cnt_reg < WC_W'(PAYLOAD_WORDS + 2)) begin
                                word_cnt_next = word_cnt_reg + WC_W'(1);
                            end
                        end else begin
                            word_cnt_next = '0;
                            out_next = '{kind: ipdd_pkg::KIND_IGNORED, pixels: '0,
                                         byte_offset: '0, byte_count: '0,
                                         frame_valid: 1'b0, last: 1'b1};
                            if (!((word_cnt_reg == '0) ? magic_now : magic_ok_reg) ||
                                !active_reg) begin
                                out_valid_next = 1'b1;
                            end else if (word_cnt_reg != WC_W'(PAYLOAD_WORDS + 1)) begin
                                good_next      = 1'b0;
                                out_next.kind  = ipdd_pkg::KIND_SIZE_ERR;
                                out_valid_next = 1'b1;
                            end else begin
                                tail_next  = s_data.data_word;
                                csum_next  = s_data.data_word[CS_W-1:0];
                                addr_next  = '0;
                                state_next = S_CRD;
                            end
                        end
                    end
                end
            end

            S_CRD: begin
                state_next = S_CFOLD;
            end

            S_CFOLD: begin
                csum_next = unit_csum;
                if (addr_reg == ADDR_W'(PAYLOAD_WORDS - 1)) begin
                    state_next = S_SEQ;
                end else begin
                    addr_next  = addr_reg + ADDR_W'(1);
                    state_next = S_CRD;
                end
            end

            S_SEQ: begin
                if (csum_reg != tail_csum) begin
                    if (out_free) begin
                        good_next      = 1'b0;
                        out_next       = '{kind: ipdd_pkg::KIND_CSUM_ERR, pixels: '0,
                                           byte_offset: '0, byte_count: '0,
                                           frame_valid: 1'b0, last: 1'b1};
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end else begin
                    if (last_vld_reg && !follows) begin
                        good_next = 1'b0;
                    end
                    last_vld_next = !idx_zero;
                    last_idx_next = tail_idx;
                    base_next     = BASE_W'(BASE_W'(tail_idx - IDX_W'(1)) * BASE_W'(PB));
                    state_next    = S_RANGE;
                end
            end

            S_RANGE: begin
                // follows was taken before last_idx moved, so keep it here
                done_next = idx_zero ? (frame_pix_reg == '0)
                                     : (in_range && (diff <= PIX_W'(PB)));
                if (in_range) begin
                    rem_next    = (diff <= PIX_W'(PB)) ? REM_W'(diff) : REM_W'(PB);
                    offset_next = PIX_W'(base_reg);
                    addr_next   = '0;
                    state_next  = S_PRD;
                end else begin
                    state_next = S_OOR;
                end
            end

            S_OOR: begin
                if (out_free) begin
                    out_next       = '{kind: ipdd_pkg::KIND_RANGE, pixels: '0,
                                       byte_offset: '0, byte_count: '0,
                                       frame_valid: 1'b0, last: !done_reg};
                    out_valid_next = 1'b1;
                    state_next     = done_reg ? S_DONE : S_IDLE;
                end
            end

            S_PRD: begin
                state_next = S_PEMIT;
            end

            S_PEMIT: begin
                if (out_free) begin
                    out_next       = '{kind: ipdd_pkg::KIND_PIXELS, pixels: unit_pix,
                                       byte_offset: offset_reg, byte_count: pix_cnt,
                                       frame_valid: 1'b0,
                                       last: (rem_reg <= REM_W'(4)) && !done_reg};
                    out_valid_next = 1'b1;
                    prev_raw_next  = unit_prev;
                    rem_next       = rem_reg - REM_W'(pix_cnt);
                    offset_next    = offset_reg + PIX_W'(4);
                    addr_next      = addr_reg + ADDR_W'(1);
                    if (rem_reg <= REM_W'(4)) begin
                        state_next = done_reg ? S_DONE : S_IDLE;
                    end else begin
                        state_next = S_PRD;
                    end
                end
            end

            S_DONE: begin
                if (out_free) begin
                    active_next    = 1'b0;
                    out_next       = '{kind: ipdd_pkg::KIND_DONE, pixels: '0,
                                       byte_offset: '0, byte_count: '0,
                                       frame_valid: good_reg, last: 1'b1};
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // previous raw byte for the first pixel of an in-range packet
        if (state_reg == S_RANGE && in_range) begin
            if (tail_idx == IDX_W'(1)) begin
                prev_raw_next = 8'd0;
            end else if (!follows_hold_reg) begin
                prev_raw_next = ipdd_pkg::PREV_GAP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            good_reg      <= 1'b0;
            last_vld_reg  <= 1'b0;
            word_cnt_reg  <= '0;
            magic_ok_reg  <= 1'b0;
            prev_raw_reg  <= 8'd0;
            frame_pix_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            good_reg      <= good_next;
            last_vld_reg  <= last_vld_next;
            word_cnt_reg  <= word_cnt_next;
            magic_ok_reg  <= magic_ok_next;
            prev_raw_reg  <= prev_raw_next;
            frame_pix_reg <= frame_pix_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg      <= out_next;
        last_idx_reg <= last_idx_next;
        tail_reg     <= tail_next;
        csum_reg     <= csum_next;
        addr_reg     <= addr_next;
        base_reg     <= base_next;
        rem_reg      <= rem_next;
        offset_reg   <= offset_next;
        done_reg     <= done_next;
        if (state_reg == S_SEQ) begin
            follows_hold_reg <= follows;
        end
    end

endmodule

`default_nettype wire
